### hw/rtl/assert_macros.svh
// Assertion helpers for the RTL. They compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Implication check, sampled on the rising clock edge, off during reset.
`define STG_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Plain condition check, sampled on the rising clock edge, off during reset.
`define STG_CHECK(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`else

`define STG_ASSERT(label, clk, rst_n, prop, msg)
`define STG_CHECK(label, clk, rst_n, cond, msg)

`endif

`endif

### hw/rtl/stg_pkg.sv
package stg_pkg;

  // Register and field widths
  localparam int unsigned RATE_W    = 18;
  localparam int unsigned HZ_W      = 17;
  localparam int unsigned CHT_W     = 4;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned CHAN_W    = 3;

  // Most copies one frame can produce
  localparam int unsigned RESULT_LIMIT = 8;

  // Parameter defaults
  localparam int unsigned INDEX_BITS_DEF   = 24;
  localparam int unsigned PHASE_BITS_DEF   = 24;
  localparam int unsigned MAX_CHANNELS_DEF = 8;

  // Register reset values
  localparam logic [RATE_W-1:0] RATE_RST = RATE_W'(48000);
  localparam logic [HZ_W-1:0]   HZ_RST   = HZ_W'(440);
  localparam logic [CHT_W-1:0]  CHT_RST  = CHT_W'(2);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RATE          = 2'd0,
    CFG_TONE_HERTZ    = 2'd1,
    CFG_CHANNEL_TOTAL = 2'd2
  } cfg_idx_e;

  // Taylor coefficients of sin(u*pi/2), Q30 magnitudes
  localparam logic [31:0] K11 = 32'd3864;
  localparam int unsigned HORNER_STEPS = 5;
  localparam logic [31:0] HORNER_COEF [HORNER_STEPS] = '{
    32'd172272, 32'd5026995, 32'd85569306, 32'd693598668, 32'd1686629713
  };

  localparam int unsigned Q_FRAC  = 30;
  localparam logic [15:0] FULL_SCALE = 16'd32767;

endpackage

### hw/rtl/sine_tone_generator.sv
// Channel   | Direction | Handshake                     | Payload
// frame     | in        | frame_valid_i / frame_stall_o | frame_index_i
// sample    | out       | sample_valid_o / sample_stall_i | sample_value_o,
//           |           |                               | channel_number_o, frame_last_o
// cfg       | in        | cfg_we_i                      | cfg_index_i, cfg_data_i
//
// Each frame fans out to its channel copies. The output port sends one copy
// per cycle while sample_stall_i is low, so the fan-out of each frame sets
// the sustained rate.
// Reset clears the valid bits and loads rate 48000, tone 440, 2 channels.
// A stall freezes the whole pipe unless its last stage holds a bubble.

module sine_tone_generator
  import stg_pkg::*;
#(
  parameter int unsigned INDEX_BITS   = INDEX_BITS_DEF,
  parameter int unsigned PHASE_BITS   = PHASE_BITS_DEF,
  parameter int unsigned MAX_CHANNELS = MAX_CHANNELS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // config write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [RATE_W-1:0]     cfg_data_i,
  // frame input
  input  logic                  frame_valid_i,
  output logic                  frame_stall_o,
  input  logic [INDEX_BITS-1:0] frame_index_i,
  // sample output
  output logic                  sample_valid_o,
  input  logic                  sample_stall_i,
  output logic [SAMPLE_W-1:0]   sample_value_o,
  output logic [CHAN_W-1:0]     channel_number_o,
  output logic                  frame_last_o
);

`include "assert_macros.svh"

  localparam int unsigned PW    = INDEX_BITS + HZ_W;   // product width
  localparam int unsigned PB    = PHASE_BITS;
  localparam int unsigned UW    = Q_FRAC + 1;          // u and s in Q30, up to 1.0
  localparam int unsigned CH_LIM_I =
    (MAX_CHANNELS < RESULT_LIMIT) ? MAX_CHANNELS : RESULT_LIMIT;
  localparam logic [CHT_W-1:0] CH_LIM = CHT_W'(CH_LIM_I);
  localparam logic [PB-2:0]    QUARTER = {1'b1, {(PB-2){1'b0}}};

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [RATE_W-1:0] rate_q;
  logic [HZ_W-1:0]   hertz_q;
  logic [CHT_W-1:0]  chans_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q  <= RATE_RST;
      hertz_q <= HZ_RST;
      chans_q <= CHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_RATE:          rate_q  <= cfg_data_i;
        CFG_TONE_HERTZ:    hertz_q <= cfg_data_i[HZ_W-1:0];
        CFG_CHANNEL_TOTAL: chans_q <= cfg_data_i[CHT_W-1:0];
        default: ;
      endcase
    end
  end

  // zero rate acts as one
  logic [RATE_W-1:0] rate_eff;
  logic [RATE_W:0]   rate_x;
  assign rate_eff = (rate_q == '0) ? RATE_W'(1) : rate_q;
  assign rate_x   = {1'b0, rate_eff};

  // copies per frame: zero acts as one, capped at the channel limit
  logic [CHT_W-1:0] n_ch;
  always_comb begin
    n_ch = (chans_q == '0) ? CHT_W'(1) : chans_q;
    if (n_ch > CH_LIM) n_ch = CH_LIM;
  end

  // ---------------------------------------------------------------------------
  // Pipeline advance: the whole pipe moves when the output register can load
  // or when the last stage holds a bubble.
  // ---------------------------------------------------------------------------
  logic out_valid_q;
  logic out_take;
  logic out_last;
  logic out_load;
  logic pipe_en;
  logic smp_v_q;

  assign out_take = out_valid_q && !sample_stall_i;
  assign out_load = !out_valid_q || (out_take && out_last);
  assign pipe_en  = out_load || !smp_v_q;
  assign frame_stall_o = !pipe_en;

  // ---------------------------------------------------------------------------
  // Stage 0: index times tone
  // ---------------------------------------------------------------------------
  logic [PW-1:0] prod_q;
  logic          prod_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_v_q <= 1'b0;
    end else if (pipe_en) begin
      prod_v_q <= frame_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      prod_q <= PW'(frame_index_i) * PW'(hertz_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Modulo stages: one product bit per stage, restoring remainder
  // ---------------------------------------------------------------------------
  logic [PW-1:0]     mprod_q [PW];
  logic [RATE_W-1:0] mrem_q  [PW];
  logic              mv_q    [PW];

  for (genvar i = 0; i < PW; i++) begin : g_mod
    logic [PW-1:0]     pin;
    logic [RATE_W-1:0] rin;
    logic              vin;
    logic [RATE_W:0]   t;
    logic [RATE_W-1:0] rnext;

    if (i == 0) begin : g_first
      assign pin = prod_q;
      assign rin = '0;
      assign vin = prod_v_q;
    end else begin : g_next
      assign pin = mprod_q[i-1];
      assign rin = mrem_q[i-1];
      assign vin = mv_q[i-1];
    end

    assign t     = {rin, pin[PW-1-i]};
    assign rnext = (t >= rate_x) ? RATE_W'(t - rate_x) : t[RATE_W-1:0];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        mv_q[i] <= 1'b0;
      end else if (pipe_en) begin
        mv_q[i] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (pipe_en) begin
        mprod_q[i] <= pin;
        mrem_q[i]  <= rnext;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Division stages: phase = (r << PB) / rate, one quotient bit per stage
  // ---------------------------------------------------------------------------
  logic [RATE_W-1:0] drem_q [PB];
  logic [PB-1:0]     dq_q   [PB];
  logic              dv_q   [PB];

  for (genvar i = 0; i < PB; i++) begin : g_div
    logic [RATE_W-1:0] rin;
    logic [PB-1:0]     qin;
    logic              vin;
    logic [RATE_W:0]   t;
    logic              qb;

    if (i == 0) begin : g_first
      assign rin = mrem_q[PW-1];
      assign qin = '0;
      assign vin = mv_q[PW-1];
    end else begin : g_next
      assign rin = drem_q[i-1];
      assign qin = dq_q[i-1];
      assign vin = dv_q[i-1];
    end

    assign t  = {rin, 1'b0};
    assign qb = (t >= rate_x);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[i] <= 1'b0;
      end else if (pipe_en) begin
        dv_q[i] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (pipe_en) begin
        drem_q[i] <= qb ? RATE_W'(t - rate_x) : t[RATE_W-1:0];
        dq_q[i]   <= {qin[PB-2:0], qb};
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Quadrant fold: mirror offset in odd quadrants, scale to Q30
  // ---------------------------------------------------------------------------
  logic [PB-1:0] phase;
  logic [PB-2:0] off_m;
  logic [UW-1:0] u_q;
  logic          uneg_q;
  logic          uv_q;

  assign phase = dq_q[PB-1];
  assign off_m = phase[PB-2] ? (QUARTER - {1'b0, phase[PB-3:0]})
                             : {1'b0, phase[PB-3:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      uv_q <= 1'b0;
    end else if (pipe_en) begin
      uv_q <= dv_q[PB-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      u_q    <= UW'(off_m) << (32 - PB);
      uneg_q <= phase[PB-1];
    end
  end

  // ---------------------------------------------------------------------------
  // s = u^2
  // ---------------------------------------------------------------------------
  logic [2*UW-1:0] usq;
  logic [UW-1:0]   s_q;
  logic [UW-1:0]   su_q;
  logic            sneg_q;
  logic            sv_q;

  assign usq = (2*UW)'(u_q) * (2*UW)'(u_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q <= 1'b0;
    end else if (pipe_en) begin
      sv_q <= uv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s_q    <= UW'(usq >> Q_FRAC);
      su_q   <= u_q;
      sneg_q <= uneg_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Horner steps, one multiply per stage
  // ---------------------------------------------------------------------------
  logic [31:0]   hp_q   [HORNER_STEPS];
  logic [UW-1:0] hs_q   [HORNER_STEPS];
  logic [UW-1:0] hu_q   [HORNER_STEPS];
  logic          hneg_q [HORNER_STEPS];
  logic          hv_q   [HORNER_STEPS];

  for (genvar i = 0; i < HORNER_STEPS; i++) begin : g_horner
    logic [31:0]   pin;
    logic [UW-1:0] sin_v;
    logic [UW-1:0] uin;
    logic          nin;
    logic          vin;
    logic [62:0]   mul;

    if (i == 0) begin : g_first
      assign pin   = K11;
      assign sin_v = s_q;
      assign uin   = su_q;
      assign nin   = sneg_q;
      assign vin   = sv_q;
    end else begin : g_next
      assign pin   = hp_q[i-1];
      assign sin_v = hs_q[i-1];
      assign uin   = hu_q[i-1];
      assign nin   = hneg_q[i-1];
      assign vin   = hv_q[i-1];
    end

    assign mul = 63'(sin_v) * 63'(pin);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        hv_q[i] <= 1'b0;
      end else if (pipe_en) begin
        hv_q[i] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (pipe_en) begin
        hp_q[i]   <= HORNER_COEF[i] - 32'(mul >> Q_FRAC);
        hs_q[i]   <= sin_v;
        hu_q[i]   <= uin;
        hneg_q[i] <= nin;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // m = u * p
  // ---------------------------------------------------------------------------
  localparam int unsigned HL = HORNER_STEPS - 1;
  logic [62:0] upm;
  logic [31:0] m_q;
  logic        mneg_q;
  logic        mval_q;

  assign upm = 63'(hu_q[HL]) * 63'(hp_q[HL]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mval_q <= 1'b0;
    end else if (pipe_en) begin
      mval_q <= hv_q[HL];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      m_q    <= 32'(upm >> Q_FRAC);
      mneg_q <= hneg_q[HL];
    end
  end

  // ---------------------------------------------------------------------------
  // Scale to full range, clamp, apply sign
  // ---------------------------------------------------------------------------
  logic [47:0]         mag_full;
  logic [17:0]         mag_sh;
  logic [SAMPLE_W-1:0] mag;
  logic [SAMPLE_W-1:0] smp_q;

  assign mag_full = 48'(m_q) * 48'(FULL_SCALE);
  assign mag_sh   = 18'(mag_full >> Q_FRAC);
  assign mag      = (mag_sh > 18'(FULL_SCALE)) ? FULL_SCALE : mag_sh[SAMPLE_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_v_q <= 1'b0;
    end else if (pipe_en) begin
      smp_v_q <= mval_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      smp_q <= mneg_q ? (SAMPLE_W'(0) - mag) : mag;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: fans each sample out across the channels
  // ---------------------------------------------------------------------------
  logic [SAMPLE_W-1:0] out_smp_q;
  logic [CHAN_W-1:0]   chan_q;

  assign out_last = ((CHT_W'(chan_q) + CHT_W'(1)) == n_ch);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      chan_q      <= '0;
    end else if (out_load) begin
      out_valid_q <= smp_v_q;
      chan_q      <= '0;
    end else if (out_take) begin
      chan_q      <= chan_q + CHAN_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_smp_q <= smp_q;
    end
  end

  assign sample_valid_o   = out_valid_q;
  assign sample_value_o   = out_smp_q;
  assign channel_number_o = chan_q;
  assign frame_last_o     = out_last;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `STG_ASSERT(a_chan_next, clk_i, rst_ni,
              (out_take && !out_last) |=> (out_valid_q && chan_q == $past(chan_q) + 3'd1),
              "channel copy skipped or dropped")
  `STG_CHECK(a_chan_range, clk_i, rst_ni,
             !out_valid_q || (CHT_W'(chan_q) < n_ch),
             "channel number beyond copy count")
  `STG_CHECK(a_no_min, clk_i, rst_ni,
             !out_valid_q || (out_smp_q != 16'h8000),
             "sample outside full scale")

endmodule

### bench/sine_tone_checker.sv
`timescale 1ns / 1ps

// Watches the config, frame and sample channels, predicts each frame's copies
// and compares them in order with what the block sends.
module sine_tone_checker
  import stg_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [RATE_W-1:0]    cfg_data_i,
  input  logic                 frame_valid_i,
  input  logic                 frame_stall_i,
  input  logic [23:0]          frame_index_i,
  input  logic                 sample_valid_i,
  input  logic                 sample_stall_i,
  input  logic [SAMPLE_W-1:0]  sample_value_i,
  input  logic [CHAN_W-1:0]    channel_number_i,
  input  logic                 frame_last_i,
  output int                   fail_count_o,
  output int                   pending_o,
  output int                   frames_seen_o,
  output int                   samples_seen_o
);

  typedef struct packed {
    logic [SAMPLE_W-1:0] value;
    logic [CHAN_W-1:0]   chan;
    logic                last;
  } copy_t;

  copy_t expected_copies[$];
  logic [RATE_W-1:0] rate_q;
  logic [HZ_W-1:0]   tone_q;
  logic [CHT_W-1:0]  chans_q;

  // floor(32767*sin(u*pi/2)), u in Q30
  function automatic longint unsigned quarter_wave(longint unsigned u);
    longint unsigned s, p, m;
    s = (u * u) >> 30;
    p = 64'd172272 - ((s * 64'd3864) >> 30);
    p = 64'd5026995 - ((s * p) >> 30);
    p = 64'd85569306 - ((s * p) >> 30);
    p = 64'd693598668 - ((s * p) >> 30);
    p = 64'd1686629713 - ((s * p) >> 30);
    m = (u * p) >> 30;
    m = (m * 64'd32767) >> 30;
    if (m > 64'd32767) m = 64'd32767;
    return m;
  endfunction

  function automatic logic [SAMPLE_W-1:0] tone_sample(logic [23:0] idx);
    longint unsigned rate, r, phase, quad, off, u, mag;
    rate  = (rate_q == 0) ? 64'd1 : 64'(rate_q);
    r     = (64'(idx) * 64'(tone_q)) % rate;
    phase = (r << 24) / rate;
    quad  = (phase >> 22) & 64'd3;
    off   = phase & 64'h3FFFFF;
    if (quad[0]) off = 64'h400000 - off;
    u = off << 8;
    if (u > 64'd1073741824) u = 64'd1073741824;
    mag = quarter_wave(u);
    if (quad[1]) return 16'((64'h10000 - mag) & 64'hFFFF);
    return 16'(mag);
  endfunction

  int mismatches;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q         <= RATE_RST;
      tone_q         <= HZ_RST;
      chans_q        <= CHT_RST;
      fail_count_o   <= 0;
      frames_seen_o  <= 0;
      samples_seen_o <= 0;
      mismatches = 0;
      expected_copies.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_RATE:          rate_q  <= cfg_data_i;
          CFG_TONE_HERTZ:    tone_q  <= cfg_data_i[HZ_W-1:0];
          CFG_CHANNEL_TOTAL: chans_q <= cfg_data_i[CHT_W-1:0];
          default: ;
        endcase
      end
      if (frame_valid_i && !frame_stall_i) begin
        int n;
        copy_t c;
        n = (chans_q == 0) ? 1 : ((chans_q > 8) ? 8 : int'(chans_q));
        c.value = tone_sample(frame_index_i);
        for (int k = 0; k < n; k++) begin
          c.chan = CHAN_W'(k);
          c.last = (k == n - 1);
          expected_copies.push_back(c);
        end
        frames_seen_o <= frames_seen_o + 1;
      end
      if (sample_valid_i && !sample_stall_i) begin
        copy_t want;
        int diff;
        samples_seen_o <= samples_seen_o + 1;
        if (expected_copies.size() == 0) begin
          fail_count_o <= fail_count_o + 1;
          if (mismatches < 10)
            $display("unexpected sample: value %0d chan %0d last %0d",
                     $signed(sample_value_i), channel_number_i, frame_last_i);
          mismatches++;
        end else begin
          want = expected_copies.pop_front();
          // sine may be off by one LSB
          diff = int'($signed(sample_value_i)) - int'($signed(want.value));
          if (diff > 1 || diff < -1 || channel_number_i != want.chan ||
              frame_last_i != want.last) begin
            fail_count_o <= fail_count_o + 1;
            if (mismatches < 10)
              $display("mismatch: want %0d/%0d/%0d got %0d/%0d/%0d",
                       $signed(want.value), want.chan, want.last,
                       $signed(sample_value_i), channel_number_i, frame_last_i);
            mismatches++;
          end
        end
      end
    end
  end

  assign pending_o = expected_copies.size();

endmodule

### bench/sine_tone_generator_test.sv
`timescale 1ns / 1ps

// Top of the bench: drives config, frames and output stalls, and gives the
// verdict. All checking lives in sine_tone_checker.
module sine_tone_generator_test;
  import stg_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;  // unmapped index
  localparam int DRAIN_CYCLES = 120;                  // longer than the pipeline's latency
  localparam int CYCLE_LIMIT  = 600000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [RATE_W-1:0]    cfg_data_i = '0;
  logic                 frame_valid_i = 1'b0;
  logic                 frame_stall_o;
  logic [23:0]          frame_index_i = '0;
  logic                 sample_valid_o;
  logic                 sample_stall_i = 1'b0;
  logic [SAMPLE_W-1:0]  sample_value_o;
  logic [CHAN_W-1:0]    channel_number_o;
  logic                 frame_last_o;

  int fail_count, pending, frames_seen, samples_seen;
  int sender_idle_pct, stall_pct;
  int cycles;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  sine_tone_generator u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .frame_valid_i, .frame_stall_o, .frame_index_i,
    .sample_valid_o, .sample_stall_i, .sample_value_o,
    .channel_number_o, .frame_last_o
  );

  sine_tone_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .frame_valid_i, .frame_stall_i(frame_stall_o), .frame_index_i,
    .sample_valid_i(sample_valid_o), .sample_stall_i, .sample_value_i(sample_value_o),
    .channel_number_i(channel_number_o), .frame_last_i(frame_last_o),
    .fail_count_o(fail_count), .pending_o(pending),
    .frames_seen_o(frames_seen), .samples_seen_o(samples_seen)
  );

  // receiver back-pressure
  always @(posedge clk_i) begin
    sample_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("sine_tone_generator_test NOT OK");
      $finish;
    end
  end

  // One frame transaction; valid stays high on return so back-to-back
  // frames need no second assignment in the same step.
  task automatic send_frame(logic [23:0] idx);
    if ($urandom_range(99) < sender_idle_pct) begin
      frame_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < sender_idle_pct);
    end
    frame_valid_i <= 1'b1;
    frame_index_i <= idx;
    // stall only moves on clock edges, so a negedge look is race free
    forever begin
      @(negedge clk_i);
      if (!frame_stall_o) break;
    end
    @(posedge clk_i);
  endtask

  // Stop sending and wait until every expected copy is out.
  task automatic drain();
    frame_valid_i <= 1'b0;
    @(posedge clk_i);
    forever begin
      @(negedge clk_i);
      if (pending == 0) break;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // cfg_we_i drops after each write, which keeps enable updates one per step
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [RATE_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_tone(int rate, int tone, int chans);
    write_reg(CFG_RATE, RATE_W'(rate));
    write_reg(CFG_TONE_HERTZ, RATE_W'(tone));
    write_reg(CFG_CHANNEL_TOTAL, RATE_W'(chans));
  endtask

  // half full-range indices, a quarter small and a quarter at the top
  function automatic logic [23:0] pick_index();
    case ($urandom_range(3))
      0:       return 24'($urandom_range(255));
      1:       return 24'hFFFFFF - 24'($urandom_range(255));
      default: return 24'($urandom);
    endcase
  endfunction

  // idle modes: none, sender 77%, receiver 77%, both 35%
  task automatic pick_mode(int m);
    case (m % 4)
      0: begin sender_idle_pct = 0;  stall_pct = 0;  end
      1: begin sender_idle_pct = 77; stall_pct = 0;  end
      2: begin sender_idle_pct = 0;  stall_pct = 77; end
      default: begin sender_idle_pct = 35; stall_pct = 35; end
    endcase
  endtask

  initial begin
    int rate, tone, chans;
    sender_idle_pct = 0;
    stall_pct = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset settings, index extremes and quadrant-ish points
    send_frame(24'd0);
    send_frame(24'd1);
    send_frame(24'hFFFFFF);
    send_frame(24'h555555);
    send_frame(24'hAAAAAA);
    send_frame(24'd27);   // near a quarter cycle at 440 Hz / 48 kHz
    send_frame(24'd55);
    send_frame(24'd82);
    drain();
    // quarter, half, three-quarter phase exactly; one channel
    set_tone(4, 1, 1);
    for (int i = 0; i < 5; i++) send_frame(24'(i));
    drain();
    // zero rate, zero channel count, unmapped index ignored
    set_tone(0, 5, 0);
    write_reg(CFG_UNUSED, '1);
    send_frame(24'd7);
    send_frame(24'hFFFFFF);
    drain();
    // zero tone, eight channels
    set_tone(192000, 0, 8);
    send_frame(24'd12345);
    drain();
    // all ones: rate/tone beyond range, channel count clipped to 8
    set_tone(262143, 131071, 15);
    send_frame(24'hFFFFFF);
    send_frame(24'h000001);
    drain();
    set_tone(192000, 96000, 9);
    send_frame(24'd1);
    send_frame(24'd2);
    drain();

    // random phases, each with its own settings and idle mode
    for (int ph = 0; ph < 12; ph++) begin
      pick_mode(ph);
      case (ph % 3)
        0: rate = $urandom_range(1, 192000);
        1: rate = $urandom_range(1, 48);
        default: rate = $urandom_range(262143);
      endcase
      tone  = (ph == 5) ? 0 : $urandom_range((ph % 4 == 3) ? 131071 : 96000);
      chans = (ph % 5 == 0) ? $urandom_range(15) : $urandom_range(1, 3);
      set_tone(rate, tone, chans);
      for (int i = 0; i < 24; i++) send_frame(pick_index());
      // one pause with the pipeline fully drained, mid-phase
      if (ph == 2) begin
        frame_valid_i <= 1'b0;
        @(posedge clk_i);
        forever begin
          @(negedge clk_i);
          if (pending == 0) break;
        end
        @(posedge clk_i);
        for (int i = 0; i < 10; i++) send_frame(pick_index());
      end
      drain();
    end

    $display("ran %0d frames giving %0d samples over 18 register settings,",
             frames_seen, samples_seen);
    $display("with and without source gaps and sink back-pressure");
    if (fail_count == 0) begin
      $display("sine_tone_generator_test OK");
    end else begin
      $display("sine_tone_generator_test NOT OK");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/stg_pkg.sv
hw/rtl/sine_tone_generator.sv
bench/sine_tone_checker.sv
bench/sine_tone_generator_test.sv
